@@ hdl/qpe_pkg.sv @@
`timescale 1ns / 1ps

package qpe_pkg;

  typedef logic [7:0] byte_t;
  typedef logic [6:0] col_t;

  localparam byte_t CH_TAB = 8'h09;
  localparam byte_t CH_LF  = 8'h0A;
  localparam byte_t CH_CR  = 8'h0D;
  localparam byte_t CH_SP  = 8'h20;
  localparam byte_t CH_DOT = 8'h2E;
  localparam byte_t CH_EQ  = 8'h3D;
  localparam byte_t CH_LO  = 8'h21;
  localparam byte_t CH_HI  = 8'h7E;

  localparam col_t LIMIT_MIN   = 7'd8;
  localparam col_t LIMIT_MAX   = 7'd76;
  localparam col_t LIMIT_RESET = 7'd76;

  typedef enum logic [1:0] {
    OP_NEWLINE,
    OP_CHAR,
    OP_HEX,
    OP_DOT
  } op_kind_t;

  // one classified byte handed from the front to the back
  typedef struct packed {
    byte_t    data;
    op_kind_t kind;
    logic     nl;
    logic     fin;
  } op_t;

  function automatic byte_t hex_digit(input logic [3:0] nib);
    byte_t d;
    if (nib < 4'd10) begin
      d = 8'h30 + {4'd0, nib};
    end else begin
      d = 8'h37 + {4'd0, nib};
    end
    return d;
  endfunction

  function automatic col_t clamp_limit(input col_t v);
    col_t l;
    if (v < LIMIT_MIN) begin
      l = LIMIT_MIN;
    end else if (v > LIMIT_MAX) begin
      l = LIMIT_MAX;
    end else begin
      l = v;
    end
    return l;
  endfunction

endpackage

@@ hdl/qpe_if.sv @@
`timescale 1ns / 1ps

interface qpe_in_if;
  logic              valid;
  logic              ready;
  qpe_pkg::byte_t    in_byte;
  logic              last_byte;
  modport source (output valid, output in_byte, output last_byte, input ready);
  modport sink (input valid, input in_byte, input last_byte, output ready);
endinterface

interface qpe_out_if;
  logic              valid;
  logic              ready;
  qpe_pkg::byte_t    out_char;
  logic              out_last;
  modport source (output valid, output out_char, output out_last, input ready);
  modport sink (input valid, input out_char, input out_last, output ready);
endinterface

interface qpe_cfg_if;
  logic              valid;
  logic              ready;
  qpe_pkg::col_t     line_limit;
  modport source (output valid, output line_limit, input ready);
  modport sink (input valid, input line_limit, output ready);
endinterface

@@ hdl/qpe_front.sv @@
`timescale 1ns / 1ps

module qpe_front (
  input  logic         clk,
  input  logic         rst_n,
  qpe_in_if.sink       in_ch,
  input  logic         q_full,
  output logic         q_push,
  output qpe_pkg::op_t q_op
);
  import qpe_pkg::*;

  byte_t      qb_r   [3];
  byte_t      qb_nxt [3];
  logic [1:0] qn_r, qn_nxt;
  logic       qend_r, qend_nxt;

  logic       pending;
  logic       has2, has3;
  logic       nl;
  logic       is_nlop;
  logic [1:0] used;
  logic [1:0] rem;
  byte_t      b;

  always_comb begin
    b       = qb_r[0];
    has2    = (qn_r >= 2'd2);
    has3    = (qn_r == 2'd3);
    pending = has3 || (qend_r && (qn_r != 2'd0));
    // a line end or the end of the data follows the front byte
    nl      = (has3 && (qb_r[1] == CH_CR) && (qb_r[2] == CH_LF))
           || (has2 && (qb_r[1] == CH_LF))
           || (qend_r && (qn_r == 2'd1));
    is_nlop = (has2 && (b == CH_CR) && (qb_r[1] == CH_LF)) || (b == CH_LF);
    used    = (is_nlop && (b == CH_CR)) ? 2'd2 : 2'd1;
    rem     = qn_r - used;

    q_op.data = b;
    q_op.nl   = nl;
    q_op.fin  = qend_r && (rem == 2'd0);
    priority if (is_nlop) begin
      q_op.kind = OP_NEWLINE;
    end else if ((b == CH_TAB) || (b == CH_SP)) begin
      q_op.kind = nl ? OP_HEX : OP_CHAR;
    end else if ((b == CH_DOT) && nl) begin
      q_op.kind = OP_DOT;
    end else if ((b >= CH_LO) && (b <= CH_HI) && (b != CH_EQ)) begin
      q_op.kind = OP_CHAR;
    end else begin
      q_op.kind = OP_HEX;
    end

    q_push      = pending && !q_full;
    in_ch.ready = !pending;
  end

  always_comb begin
    qb_nxt   = qb_r;
    qn_nxt   = qn_r;
    qend_nxt = qend_r;
    if (q_push) begin
      if (used == 2'd1) begin
        qb_nxt[0] = qb_r[1];
        qb_nxt[1] = qb_r[2];
      end else begin
        qb_nxt[0] = qb_r[2];
      end
      qn_nxt = rem;
    end else if (in_ch.valid && !pending) begin
      qb_nxt[qn_r] = in_ch.in_byte;
      qn_nxt       = qn_r + 2'd1;
      qend_nxt     = in_ch.last_byte;
    end
  end

  always_ff @(posedge clk) begin
    qb_r <= qb_nxt;
    if (!rst_n) begin
      qn_r   <= 2'd0;
      qend_r <= 1'b0;
    end else begin
      qn_r   <= qn_nxt;
      qend_r <= qend_nxt;
    end
  end

  // the closing byte of the data leaves nothing behind
  a_fin_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (q_push && q_op.fin) |=> (qn_r == 2'd0))
    else $error("lookahead not empty after final byte");

endmodule

@@ hdl/qpe_queue.sv @@
`timescale 1ns / 1ps

module qpe_queue #(
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  qpe_pkg::op_t push_op,
  output logic         full,
  input  logic         pop,
  output qpe_pkg::op_t pop_op,
  output logic         not_empty
);
  import qpe_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  op_t           mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  always_comb begin
    full       = (count_r == CW'(DEPTH));
    not_empty  = (count_r != '0);
    pop_op     = mem_r[rd_ptr_r];
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    unique case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("queue overrun");

endmodule

@@ hdl/qpe_back.sv @@
`timescale 1ns / 1ps

module qpe_back (
  input  logic          clk,
  input  logic          rst_n,
  input  qpe_pkg::col_t limit,
  input  logic          op_valid,
  input  qpe_pkg::op_t  op,
  output logic          op_pop,
  qpe_out_if.source     out_ch
);
  import qpe_pkg::*;

  typedef enum logic [8:0] {
    P_IDLE  = 9'b000000001,
    P_SB_EQ = 9'b000000010,
    P_SB_CR = 9'b000000100,
    P_SB_LF = 9'b000001000,
    P_B0    = 9'b000010000,
    P_B1    = 9'b000100000,
    P_B2    = 9'b001000000,
    P_T_CR  = 9'b010000000,
    P_T_LF  = 9'b100000000
  } phase_t;

  phase_t phase_r, phase_nxt, phase_after;
  col_t   column_r, column_nxt;
  byte_t  cur_byte_r;
  logic   cur_hex_r, cur_nlop_r, cur_fin_r;
  logic   out_valid_r, out_valid_nxt;
  byte_t  out_char_r, out_char_nxt;
  logic   out_last_r, out_last_nxt;

  logic       dot_hex, ld_hex, ld_sb, ld_nlop;
  logic [7:0] need, sum, lim8;
  col_t       col_after;
  logic       can_emit, emit, trail;
  byte_t      emit_char;
  logic       emit_last;

  // classification meets the column when an op is taken
  always_comb begin
    ld_nlop   = (op.kind == OP_NEWLINE);
    dot_hex   = (op.kind == OP_DOT) && (column_r == '0);
    ld_hex    = (op.kind == OP_HEX) || dot_hex;
    need      = ld_hex ? 8'd3 : 8'd1;
    sum       = {1'b0, column_r} + need;
    lim8      = {1'b0, limit};
    ld_sb     = !ld_nlop && !dot_hex && ((sum > lim8) || ((sum == lim8) && !op.nl));
    col_after = ld_sb ? need[6:0] : sum[6:0];
    op_pop    = (phase_r == P_IDLE) && op_valid;
  end

  always_comb begin
    trail       = cur_fin_r && !cur_nlop_r;
    emit_char   = '0;
    emit_last   = 1'b0;
    phase_after = P_IDLE;
    unique case (phase_r)
      P_IDLE: begin
        phase_after = P_IDLE;
      end
      P_SB_EQ: begin
        emit_char   = CH_EQ;
        phase_after = P_SB_CR;
      end
      P_SB_CR: begin
        emit_char   = CH_CR;
        phase_after = P_SB_LF;
      end
      P_SB_LF: begin
        emit_char   = CH_LF;
        phase_after = P_B0;
      end
      P_B0: begin
        if (cur_nlop_r) begin
          emit_char   = CH_CR;
          phase_after = P_B1;
        end else if (cur_hex_r) begin
          emit_char   = CH_EQ;
          phase_after = P_B1;
        end else begin
          emit_char   = cur_byte_r;
          phase_after = trail ? P_T_CR : P_IDLE;
        end
      end
      P_B1: begin
        if (cur_nlop_r) begin
          emit_char   = CH_LF;
          emit_last   = cur_fin_r;
          phase_after = P_IDLE;
        end else begin
          emit_char   = hex_digit(cur_byte_r[7:4]);
          phase_after = P_B2;
        end
      end
      P_B2: begin
        emit_char   = hex_digit(cur_byte_r[3:0]);
        phase_after = trail ? P_T_CR : P_IDLE;
      end
      P_T_CR: begin
        emit_char   = CH_CR;
        phase_after = P_T_LF;
      end
      P_T_LF: begin
        emit_char   = CH_LF;
        emit_last   = 1'b1;
        phase_after = P_IDLE;
      end
      default: begin
        phase_after = P_IDLE;
      end
    endcase

    can_emit = !out_valid_r || out_ch.ready;
    emit     = (phase_r != P_IDLE) && can_emit;

    phase_nxt  = phase_r;
    column_nxt = column_r;
    if (op_pop) begin
      phase_nxt  = ld_sb ? P_SB_EQ : P_B0;
      column_nxt = (ld_nlop || op.fin) ? '0 : col_after;
    end else if (emit) begin
      phase_nxt = phase_after;
    end

    out_valid_nxt = out_valid_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_char_nxt  = emit_char;
      out_last_nxt  = emit_last;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    out_ch.valid    = out_valid_r;
    out_ch.out_char = out_char_r;
    out_ch.out_last = out_last_r;
  end

  always_ff @(posedge clk) begin
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
    if (op_pop) begin
      cur_byte_r <= op.data;
      cur_hex_r  <= ld_hex;
      cur_nlop_r <= ld_nlop;
      cur_fin_r  <= op.fin;
    end
    if (!rst_n) begin
      phase_r     <= P_IDLE;
      column_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      column_r    <= column_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_column_bound: assert property (@(posedge clk) disable iff (!rst_n)
    column_r <= LIMIT_MAX)
    else $error("column beyond line limit");

  a_last_is_lf: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.out_last) |-> (out_ch.out_char == CH_LF))
    else $error("final character is not a line feed");

  a_fin_column: assert property (@(posedge clk) disable iff (!rst_n)
    ((phase_r != P_IDLE) && cur_fin_r) |-> (column_r == '0))
    else $error("column not cleared at end of data");

endmodule

@@ hdl/quoted_printable_encoder_unit.sv @@
// Quoted-printable encoder: raw bytes with a last flag in, encoded characters out. A front
// stage holds two bytes of lookahead and classifies each byte (line end, plain, hex
// escape, lone dot) into a small queue; a back sequencer applies the column and line
// limit, inserting soft breaks, and drives the registered output. The front takes a byte
// in any cycle in which it holds no byte waiting for the queue. The back sequencer takes
// a new operation only once it has written every character of the last one, and it
// stalls while the output is held; a line end is one operation that covers both bytes
// of a CR LF pair. The line limit write is taken at once and saturated into 8..76.
`timescale 1ns / 1ps

module quoted_printable_encoder_unit #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  qpe_in_if.sink    in_ch,
  qpe_out_if.source out_ch,
  qpe_cfg_if.sink   cfg_ch
);
  import qpe_pkg::*;

  col_t limit_r, limit_nxt;
  logic q_full, q_push, q_pop, q_valid;
  op_t  push_op, pop_op;

  always_comb begin
    cfg_ch.ready = 1'b1;
    limit_nxt    = limit_r;
    if (cfg_ch.valid) begin
      limit_nxt = clamp_limit(cfg_ch.line_limit);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
    end else begin
      limit_r <= limit_nxt;
    end
  end

  qpe_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_op   (push_op)
  );

  qpe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_op   (push_op),
    .full      (q_full),
    .pop       (q_pop),
    .pop_op    (pop_op),
    .not_empty (q_valid)
  );

  qpe_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .limit    (limit_r),
    .op_valid (q_valid),
    .op       (pop_op),
    .op_pop   (q_pop),
    .out_ch   (out_ch)
  );

endmodule

@@ tb/qp_encode_checker.sv @@
`timescale 1ns / 1ps

module qp_encode_checker (
  input  logic clk,
  input  logic rst_n,
  qpe_in_if    in_ch,
  qpe_out_if   out_ch,
  qpe_cfg_if   cfg_ch,
  output int   fail_count,
  output int   pending,
  output int   chars_checked
);
  import qpe_pkg::*;

  typedef struct packed {
    byte_t ch;
    logic  last;
  } qp_char_t;

  qp_char_t expected_chars[$];

  col_t  limit_reg;
  byte_t held[2];
  int    held_cnt;
  int    col;

  // working window: held bytes plus the new one
  byte_t win[3];
  int    win_n;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] %s mismatch on character %0d: got %02h, expected %02h",
             $realtime, what, chars_checked, got, want);
    fail_count++;
  endtask

  function automatic int eff_limit();
    int l;
    l = limit_reg;
    if (l < LIMIT_MIN) l = LIMIT_MIN;
    if (l > LIMIT_MAX) l = LIMIT_MAX;
    return l;
  endfunction

  function automatic byte_t nibble_char(input logic [3:0] v);
    return (v < 4'd10) ? 8'd48 + v : 8'd55 + v;
  endfunction

  function automatic void emit_char(input byte_t c);
    qp_char_t e;
    e.ch   = c;
    e.last = 1'b0;
    expected_chars.push_back(e);
  endfunction

  function automatic void emit_plain(input byte_t c);
    emit_char(c);
    col = col + 1;
  endfunction

  function automatic void emit_escape(input byte_t c);
    emit_char(CH_EQ);
    emit_char(nibble_char(c[7:4]));
    emit_char(nibble_char(c[3:0]));
    col = col + 3;
  endfunction

  // a character may end exactly at the limit without a soft break only if a line end follows
  function automatic void soft_break(input int need, input bit at_eol);
    int lim;
    lim = eff_limit();
    if (col + need > lim || (col + need == lim && !at_eol)) begin
      emit_char(CH_EQ);
      emit_char(CH_CR);
      emit_char(CH_LF);
      col = 0;
    end
  endfunction

  function automatic int encode_head(input bit fin);
    byte_t b;
    bit    at_eol;
    b = win[0];
    at_eol = (win_n > 2 && win[1] == CH_CR && win[2] == CH_LF) ||
             (win_n > 1 && win[1] == CH_LF) || (fin && win_n == 1);
    if ((win_n > 1 && b == CH_CR && win[1] == CH_LF) || b == CH_LF) begin
      emit_char(CH_CR);
      emit_char(CH_LF);
      col = 0;
      return (b == CH_CR) ? 2 : 1;
    end
    if (b == CH_TAB || b == CH_SP) begin
      if (at_eol) begin
        soft_break(3, 1'b1);
        emit_escape(b);
      end else begin
        soft_break(1, 1'b0);
        emit_plain(b);
      end
    end else if (col == 0 && b == CH_DOT && at_eol) begin
      // lone dot goes out escaped, no soft break check
      emit_escape(b);
    end else if (b >= CH_LO && b <= CH_HI && b != CH_EQ) begin
      soft_break(1, at_eol);
      emit_plain(b);
    end else begin
      soft_break(3, at_eol);
      emit_escape(b);
    end
    return 1;
  endfunction

  task automatic predict_byte(input byte_t b, input logic fin);
    int       used;
    int       base;
    qp_char_t tail;
    base  = expected_chars.size();
    win_n = held_cnt;
    win[0] = held[0];
    win[1] = held[1];
    win[win_n] = b;
    win_n++;
    while (win_n > 0 && (fin || win_n == 3)) begin
      used = encode_head(fin);
      for (int i = 0; i + used < win_n; i++) win[i] = win[i + used];
      win_n -= used;
      if (!fin) break;
    end
    if (fin) begin
      if (col != 0) begin
        emit_char(CH_CR);
        emit_char(CH_LF);
      end
      col      = 0;
      held_cnt = 0;
      if (expected_chars.size() > base) begin
        tail      = expected_chars.pop_back();
        tail.last = 1'b1;
        expected_chars.push_back(tail);
      end
    end else begin
      held[0]  = win[0];
      held[1]  = win[1];
      held_cnt = win_n;
    end
  endtask

  always @(posedge clk) begin
    qp_char_t want;
    if (!rst_n) begin
      limit_reg = LIMIT_RESET;
      held_cnt  = 0;
      col       = 0;
      expected_chars.delete();
    end else begin
      // results first, so a word accepted on this edge never matches its own input
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        if (expected_chars.size() == 0) begin
          report_mismatch("unexpected word", out_ch.out_char, 0);
        end else begin
          want = expected_chars.pop_front();
          if (out_ch.out_char !== want.ch)
            report_mismatch("out_char", out_ch.out_char, want.ch);
          if (out_ch.out_last !== want.last)
            report_mismatch("out_last", out_ch.out_last, want.last);
        end
        chars_checked++;
      end
      if (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1)
        limit_reg = cfg_ch.line_limit;
      if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1)
        predict_byte(in_ch.in_byte, in_ch.last_byte);
    end
    pending = expected_chars.size();
  end

endmodule

@@ tb/quoted_printable_encoder_unit_tb.sv @@
`timescale 1ns / 1ps

module quoted_printable_encoder_unit_tb;
  import qpe_pkg::*;

  localparam int CYCLE_LIMIT      = 400000;
  localparam int HOLD_CYCLES      = 200;
  localparam int PHASE_BYTES      = 30;
  localparam int LONG_PHASE_BYTES = 78;
  localparam int SETTLE_CYCLES    = 12;

  logic clk = 1'b0;
  logic rst_n;

  qpe_in_if  in_ch ();
  qpe_out_if out_ch ();
  qpe_cfg_if cfg_ch ();

  int fail_count;
  int pending;
  int chars_checked;

  int  cycle_cnt = 0;
  int  bytes_sent = 0;
  int  msgs_sent = 0;
  int  limits_written = 0;
  bit  idle_on = 1'b0;
  bit  stall_on = 1'b0;
  bit  hold_req = 1'b0;

  byte_t msg_q[$];

  quoted_printable_encoder_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  qp_encode_checker checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .cfg_ch        (cfg_ch),
    .fail_count    (fail_count),
    .pending       (pending),
    .chars_checked (chars_checked)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d characters outstanding", cycle_cnt, pending);
      $display("quoted_printable_encoder_unit verification failed");
      $finish;
    end
  end

  // result side: random stalls, and one long hold when asked for
  initial begin
    int gap;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      gap = stall_on ? $urandom_range(0, 4) : 0;
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
    end
  end

  task automatic send_byte(input byte_t b, input logic fin);
    int gap;
    gap = idle_on ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.in_byte   <= b;
    in_ch.last_byte <= fin;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    bytes_sent++;
  endtask

  task automatic send_msg();
    foreach (msg_q[i]) send_byte(msg_q[i], i == msg_q.size() - 1);
    msgs_sent++;
    msg_q.delete();
  endtask

  // wait for every expected word, then let the block settle
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(input col_t v);
    cfg_ch.valid      <= 1'b1;
    cfg_ch.line_limit <= v;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    cfg_ch.valid <= 1'b0;
    limits_written++;
  endtask

  // text-like content: dense mode keeps lines long enough to force soft breaks
  task automatic build_msg(input int len, input bit dense);
    int r;
    while (msg_q.size() < len) begin
      r = dense ? $urandom_range(0, 62) : $urandom_range(0, 99);
      if (r < 40 || r > 88) begin
        msg_q.push_back(byte_t'($urandom_range(CH_LO, CH_HI)));
      end else if (r < 48) begin
        msg_q.push_back(CH_SP);
      end else if (r < 53) begin
        msg_q.push_back(CH_TAB);
      end else if (r < 58) begin
        msg_q.push_back(CH_EQ);
      end else if (r < 63) begin
        msg_q.push_back(byte_t'($urandom_range(0, 255)));
      end else if (r < 71) begin
        msg_q.push_back(CH_CR);
        msg_q.push_back(CH_LF);
      end else if (r < 76) begin
        msg_q.push_back(CH_LF);
      end else if (r < 79) begin
        // bare cr followed by ordinary text
        msg_q.push_back(CH_CR);
        msg_q.push_back(byte_t'($urandom_range(CH_LO, CH_HI)));
      end else if (r < 84) begin
        msg_q.push_back(CH_LF);
        msg_q.push_back(CH_DOT);
        if ($urandom_range(0, 1)) begin
          msg_q.push_back(CH_CR);
        end
        msg_q.push_back(CH_LF);
      end else begin
        msg_q.push_back($urandom_range(0, 1) ? CH_SP : CH_TAB);
        msg_q.push_back(CH_LF);
      end
    end
  endtask

  initial begin
    col_t  limits[8];
    int    phase_bytes;
    int    budget;
    int    len;
    bit    dense;
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.in_byte     <= '0;
    in_ch.last_byte   <= 1'b0;
    cfg_ch.valid      <= 1'b0;
    cfg_ch.line_limit <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed, at the reset line limit: printable extremes, escapes, trailing
    // whitespace, lone dot, bare cr, whitespace at end of data
    msg_q = '{"!", "~", CH_EQ, 8'h00, 8'hFF, 8'h7F, CH_SP, CH_TAB, CH_CR, CH_LF,
              CH_DOT, CH_CR, CH_LF, CH_SP, CH_LF, CH_CR, "q", CH_TAB};
    send_msg();
    msg_q = '{CH_DOT};
    send_msg();
    msg_q = '{CH_LF};
    send_msg();
    msg_q = '{"a", CH_CR};
    send_msg();
    drain();

    limits[0] = LIMIT_MIN;
    limits[1] = LIMIT_MAX;
    limits[2] = 7'd0;
    limits[3] = 7'd127;
    limits[4] = LIMIT_MIN - 7'd1;
    limits[5] = LIMIT_MAX + 7'd1;
    limits[6] = col_t'($urandom_range(9, 75));
    limits[7] = col_t'($urandom_range(0, 127));

    for (int ph = 0; ph < 8; ph++) begin
      write_limit(limits[ph]);
      idle_on  = (ph % 3 != 0);
      stall_on = (ph % 4 != 1);
      budget   = (ph == 1) ? LONG_PHASE_BYTES : PHASE_BYTES;
      phase_bytes = 0;
      // fill the block while results are held back, with one line past the full limit
      if (ph == 1) begin
        hold_req = 1'b1;
        build_msg(budget, 1'b1);
        phase_bytes += msg_q.size();
        send_msg();
      end
      while (phase_bytes < budget) begin
        dense = ($urandom_range(0, 5) == 0);
        len   = dense ? $urandom_range(20, 85) : $urandom_range(1, 16);
        if (len > budget - phase_bytes) len = budget - phase_bytes;
        build_msg(len, dense);
        phase_bytes += msg_q.size();
        send_msg();
      end
      drain();
    end

    $display("sent %0d bytes in %0d messages under %0d line limit settings",
             bytes_sent, msgs_sent, limits_written + 1);
    $display("compared %0d encoded characters, %0d mismatches", chars_checked, fail_count);
    if (fail_count == 0) begin
      $display("quoted_printable_encoder_unit verification clean");
    end else begin
      $display("quoted_printable_encoder_unit verification failed");
    end
    $finish;
  end

endmodule
